[rtl/product_additive_code_decoder_unit_defines.svh]
`ifndef PRODUCT_ADDITIVE_CODE_DECODER_UNIT_DEFINES_SVH
`define PRODUCT_ADDITIVE_CODE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PACD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PACD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pacd_pkg.sv]
`timescale 1ns / 1ps

package pacd_pkg;

   // Codebook geometry
   localparam int NSplits        = 2;
   localparam int MSub           = 4;
   localparam int NBits          = 8;
   localparam int DSub           = 16;
   localparam int EntriesPerBook = 1 << NBits;
   localparam int NRows          = NSplits * MSub * EntriesPerBook;
   localparam int StoreDepth     = NRows * DSub;
   localparam int AddrW          = $clog2(StoreDepth);

   // Counter widths, at least one bit each
   localparam int SplitW = (NSplits > 1) ? $clog2(NSplits) : 1;
   localparam int MSubW  = (MSub > 1) ? $clog2(MSub) : 1;
   localparam int DSubW  = (DSub > 1) ? $clog2(DSub) : 1;

   // Field widths
   localparam int CodeW     = 64;
   localparam int IdxBits   = NSplits * MSub * NBits;
   localparam int CodeExtW  = (IdxBits > CodeW) ? IdxBits : CodeW;
   localparam int BitPosW   = $clog2(CodeExtW);
   localparam int RowW      = 11;
   localparam int DimInW    = 4;
   localparam int ElemW     = 16;
   localparam int OutDimW   = 5;
   localparam int OutValueW = 18;

   // Command codes
   localparam logic CmdWrite  = 1'b0;
   localparam logic CmdDecode = 1'b1;

endpackage

[rtl/pacd_req_if.sv]
`timescale 1ns / 1ps

interface pacd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  cmd;
   logic        [pacd_pkg::RowW-1:0]      row_index;
   logic        [pacd_pkg::DimInW-1:0]    dim_index;
   logic signed [pacd_pkg::ElemW-1:0]     element_value;
   logic        [pacd_pkg::CodeW-1:0]     packed_code;

   modport source (output valid, cmd, row_index, dim_index, element_value, packed_code,
                   input ready);
   modport sink (input valid, cmd, row_index, dim_index, element_value, packed_code,
                 output ready);
endinterface

[rtl/pacd_rsp_if.sv]
`timescale 1ns / 1ps

interface pacd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [pacd_pkg::OutDimW-1:0]   out_dim;
   logic signed [pacd_pkg::OutValueW-1:0] out_value;
   logic                                  last;

   modport source (output valid, out_dim, out_value, last, input ready);
   modport sink (input valid, out_dim, out_value, last, output ready);
endinterface

[rtl/product_additive_code_decoder_unit.sv]
// Codebook write (cmd 0): taken only while no decode is issuing reads.
// Decode (cmd 1): NSPLITS*MSUB*DSUB single-port codebook reads, one per cycle
// unless a full output register stalls them (128 by default); no new request is
// taken until the last read has issued. Each result is the sum of MSUB reads and
// leaves through the read data, accumulator and output registers. Synchronous
// active-high reset clears control; the codebook holds no reset value.
`timescale 1ns / 1ps
`include "product_additive_code_decoder_unit_defines.svh"

module product_additive_code_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   pacd_req_if.sink    req,
   pacd_rsp_if.source  rsp
);

   typedef enum logic {IDLE, BUSY} state_type;

   typedef struct packed {
      logic                             first;
      logic                             fin;
      logic                             last;
      logic [pacd_pkg::OutDimW-1:0]     dim;
   } tag_type;

   state_type                              state_ff, state_in;
   logic [pacd_pkg::SplitW-1:0]            split_ff, split_in;
   logic [pacd_pkg::MSubW-1:0]             stage_ff, stage_in;
   logic [pacd_pkg::DSubW-1:0]             elem_ff, elem_in;
   logic [pacd_pkg::CodeW-1:0]             code_ff, code_in;
   logic                                   rd_valid_ff, rd_valid_in;
   tag_type                                rd_tag_ff, rd_tag_in;
   logic signed [pacd_pkg::OutValueW-1:0]  acc_ff, acc_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [pacd_pkg::OutDimW-1:0]           rsp_dim_ff, rsp_dim_in;
   logic signed [pacd_pkg::OutValueW-1:0]  rsp_value_ff, rsp_value_in;
   logic                                   rsp_last_ff, rsp_last_in;

   logic signed [pacd_pkg::ElemW-1:0]      codebook_mem [pacd_pkg::StoreDepth];
   logic signed [pacd_pkg::ElemW-1:0]      rdata_ff;

   logic                                   req_accept;
   logic                                   out_free;
   logic                                   stall;
   logic                                   mem_re;
   logic                                   mem_we;
   logic [pacd_pkg::AddrW-1:0]             mem_addr;
   logic [31:0]                            stage_num;
   logic [pacd_pkg::BitPosW-1:0]           bit_pos;
   logic [pacd_pkg::CodeExtW-1:0]          code_ext;
   logic [pacd_pkg::NBits-1:0]             idx;
   logic [31:0]                            rd_addr_full;
   logic [31:0]                            wr_addr_full;
   logic [31:0]                            dim_full;
   logic                                   last_stage;
   logic                                   last_elem;
   logic                                   last_split;
   tag_type                                issue_tag;
   logic signed [pacd_pkg::OutValueW-1:0]  elem_ext;
   logic signed [pacd_pkg::OutValueW-1:0]  sum;
   logic                                   process;
   logic                                   rsp_on_last_dim;

   // Handshake and pipeline control
   assign req.ready  = (state_ff == IDLE);
   assign req_accept = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign stall      = rd_valid_ff && rd_tag_ff.fin && !out_free;
   assign mem_re     = (state_ff == BUSY) && !stall;
   assign process    = rd_valid_ff && !stall;

   // Pick the index of the current stage from the code word
   assign stage_num = 32'(split_ff) * 32'(pacd_pkg::MSub) + 32'(stage_ff);
   assign bit_pos   = pacd_pkg::BitPosW'(stage_num * 32'(pacd_pkg::NBits));
   assign code_ext  = pacd_pkg::CodeExtW'(code_ff);
   assign idx       = code_ext[bit_pos +: pacd_pkg::NBits];

   // Form read and write addresses on the single port
   assign rd_addr_full = (stage_num * 32'(pacd_pkg::EntriesPerBook) + 32'(idx))
                         * 32'(pacd_pkg::DSub) + 32'(elem_ff);
   assign wr_addr_full = 32'(req.row_index) * 32'(pacd_pkg::DSub) + 32'(req.dim_index);
   assign mem_we   = req_accept && (req.cmd == pacd_pkg::CmdWrite)
                     && (32'(req.row_index) < 32'(pacd_pkg::NRows))
                     && (32'(req.dim_index) < 32'(pacd_pkg::DSub));
   assign mem_addr = mem_we ? wr_addr_full[pacd_pkg::AddrW-1:0]
                            : rd_addr_full[pacd_pkg::AddrW-1:0];

   // Codebook memory, one access per cycle, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         codebook_mem[mem_addr] <= req.element_value;
      end
      if (mem_re) begin
         rdata_ff <= codebook_mem[mem_addr];
      end
   end

   // Tag the read being issued
   assign last_stage = (stage_ff == pacd_pkg::MSubW'(pacd_pkg::MSub - 1));
   assign last_elem  = (elem_ff == pacd_pkg::DSubW'(pacd_pkg::DSub - 1));
   assign last_split = (split_ff == pacd_pkg::SplitW'(pacd_pkg::NSplits - 1));
   assign dim_full   = 32'(split_ff) * 32'(pacd_pkg::DSub) + 32'(elem_ff);

   always_comb begin
      issue_tag.first = (stage_ff == '0);
      issue_tag.fin   = last_stage;
      issue_tag.last  = last_elem && last_split;
      issue_tag.dim   = dim_full[pacd_pkg::OutDimW-1:0];
   end

   // Accumulate the stages of one dimension
   assign elem_ext = pacd_pkg::OutValueW'(rdata_ff);
   assign sum      = (rd_tag_ff.first ? '0 : acc_ff) + elem_ext;

   // Next state of the sequencer and the output register
   always_comb begin
      state_in     = state_ff;
      split_in     = split_ff;
      stage_in     = stage_ff;
      elem_in      = elem_ff;
      code_in      = code_ff;
      rd_valid_in  = stall ? rd_valid_ff : mem_re;
      rd_tag_in    = mem_re ? issue_tag : rd_tag_ff;
      acc_in       = process ? sum : acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dim_in   = rsp_dim_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         IDLE: begin
            if (req_accept && (req.cmd == pacd_pkg::CmdDecode)) begin
               state_in = BUSY;
               split_in = '0;
               stage_in = '0;
               elem_in  = '0;
               code_in  = req.packed_code;
            end
         end
         BUSY: begin
            if (mem_re) begin
               if (!last_stage) begin
                  stage_in = stage_ff + pacd_pkg::MSubW'(1);
               end else begin
                  stage_in = '0;
                  if (!last_elem) begin
                     elem_in = elem_ff + pacd_pkg::DSubW'(1);
                  end else begin
                     elem_in = '0;
                     if (!last_split) begin
                        split_in = split_ff + pacd_pkg::SplitW'(1);
                     end else begin
                        split_in = '0;
                        state_in = IDLE;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      // Load a finished sum into the output beat, or drop a taken beat
      if (process && rd_tag_ff.fin) begin
         rsp_valid_in = 1'b1;
         rsp_dim_in   = rd_tag_ff.dim;
         rsp_value_in = sum;
         rsp_last_in  = rd_tag_ff.last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         split_ff     <= '0;
         stage_ff     <= '0;
         elem_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         split_ff     <= split_in;
         stage_ff     <= stage_in;
         elem_ff      <= elem_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff      <= code_in;
      rd_tag_ff    <= rd_tag_in;
      acc_ff       <= acc_in;
      rsp_dim_ff   <= rsp_dim_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_dim   = rsp_dim_ff;
   assign rsp.out_value = rsp_value_ff;
   assign rsp.last      = rsp_last_ff;

   // Checks on sequencing and the shared port
   assign rsp_on_last_dim =
      (rsp.out_dim == pacd_pkg::OutDimW'(pacd_pkg::NSplits * pacd_pkg::DSub - 1));

   `PACD_ASSERT_NOW(a_no_read_on_stall, clock, reset, stall, !mem_re, "read during stall")
   `PACD_ASSERT_NOW(a_port_exclusive, clock, reset, mem_we, !mem_re && req.ready, "port clash")
   `PACD_ASSERT_NEXT(a_stall_holds_data, clock, reset, stall, $stable(rdata_ff) && rd_valid_ff, "stall lost data")
   `PACD_ASSERT_NOW(a_last_on_final_dim, clock, reset, rsp.valid && rsp.last, rsp_on_last_dim, "last misplaced")

endmodule

[verif/product_additive_code_decoder_unit_test.sv]
`timescale 1ns / 1ps

module product_additive_code_decoder_unit_test;

   localparam int Stages      = pacd_pkg::NSplits * pacd_pkg::MSub;
   localparam int WatchLimit  = 4000;
   localparam int TailCycles  = 200;
   localparam int RandomItems = 128;
   localparam int Segments    = 8;

   typedef enum int {PaceFree, PaceSendIdle, PaceRecvStall, PaceBoth} pace_type;
   typedef enum int {FillRandom, FillMin, FillMax} fill_type;

   typedef struct packed {
      logic                              cmd;
      logic [pacd_pkg::RowW-1:0]         row_index;
      logic [pacd_pkg::DimInW-1:0]       dim_index;
      logic signed [pacd_pkg::ElemW-1:0] element_value;
      logic [pacd_pkg::CodeW-1:0]        packed_code;
   } req_beat_type;

   typedef struct packed {
      logic [pacd_pkg::OutDimW-1:0]          out_dim;
      logic signed [pacd_pkg::OutValueW-1:0] out_value;
      logic                                  last;
   } rsp_beat_type;

   logic clock;
   logic reset;

   pacd_req_if req ();
   pacd_rsp_if rsp ();

   product_additive_code_decoder_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // Beats waiting to be sent, and reconstructed elements still owed by the block
   req_beat_type req_backlog[$];
   rsp_beat_type expected_dims[$];

   // Mirror of the codebook, plus which rows the stimulus has fully loaded
   logic signed [pacd_pkg::ElemW-1:0] book_mirror[pacd_pkg::StoreDepth];
   bit                                row_full[pacd_pkg::NRows];
   int                                full_list[Stages][pacd_pkg::EntriesPerBook];
   int                                full_cnt[Stages];

   int pushed_cnt     = 0;
   int accepted_cnt   = 0;
   int mismatch_cnt   = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic set_pace(input pace_type p);
      case (p)
         PaceFree: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         PaceSendIdle: begin
            send_idle_pct  = 57;
            recv_stall_pct = 0;
         end
         PaceRecvStall: begin
            send_idle_pct  = 0;
            recv_stall_pct = 57;
         end
         default: begin
            send_idle_pct  = 16;
            recv_stall_pct = 16;
         end
      endcase
   endtask

   task automatic queue_beat(input req_beat_type b);
      req_backlog.insert(req_backlog.size(), b);
      pushed_cnt++;
   endtask

   task automatic push_write(input int row, input int dim,
                             input logic signed [pacd_pkg::ElemW-1:0] v);
      req_beat_type b;
      b.cmd           = pacd_pkg::CmdWrite;
      b.row_index     = row[pacd_pkg::RowW-1:0];
      b.dim_index     = dim[pacd_pkg::DimInW-1:0];
      b.element_value = v;
      b.packed_code   = {$urandom, $urandom};
      queue_beat(b);
   endtask

   task automatic push_decode(input logic [pacd_pkg::CodeW-1:0] code);
      req_beat_type b;
      b.cmd           = pacd_pkg::CmdDecode;
      b.row_index     = pacd_pkg::RowW'($urandom_range(0, pacd_pkg::NRows - 1));
      b.dim_index     = pacd_pkg::DimInW'($urandom_range(0, (1 << pacd_pkg::DimInW) - 1));
      b.element_value = pacd_pkg::ElemW'($urandom);
      b.packed_code   = code;
      queue_beat(b);
   endtask

   // Load one whole row in shuffled dimension order
   task automatic load_row(input int stage, input int idx, input fill_type fill);
      int order[pacd_pkg::DSub];
      int row;
      int j;
      int t;
      logic signed [pacd_pkg::ElemW-1:0] v;
      row = stage * pacd_pkg::EntriesPerBook + idx;
      for (int i = 0; i < pacd_pkg::DSub; i++) order[i] = i;
      for (int i = pacd_pkg::DSub - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < pacd_pkg::DSub; i++) begin
         case (fill)
            FillMin: v = {1'b1, {(pacd_pkg::ElemW - 1){1'b0}}};
            FillMax: v = {1'b0, {(pacd_pkg::ElemW - 1){1'b1}}};
            default: v = pacd_pkg::ElemW'($urandom);
         endcase
         push_write(row, order[i], v);
      end
      if (!row_full[row]) begin
         row_full[row] = 1'b1;
         full_list[stage][full_cnt[stage]] = idx;
         full_cnt[stage]++;
      end
   endtask

   // Build a code word that only selects rows already loaded
   function automatic logic [pacd_pkg::CodeW-1:0] pick_code();
      logic [pacd_pkg::CodeW-1:0] code;
      code = '0;
      for (int st = 0; st < Stages; st++)
         code[st * pacd_pkg::NBits +: pacd_pkg::NBits] =
            pacd_pkg::NBits'(full_list[st][$urandom_range(0, full_cnt[st] - 1)]);
      return code;
   endfunction

   // Sum the selected rows per split and queue one element per dimension
   task automatic predict_decode(input logic [pacd_pkg::CodeW-1:0] code);
      int           rows[pacd_pkg::MSub];
      int           acc;
      int           stage;
      int           idx;
      int           pos;
      rsp_beat_type e;
      for (int s = 0; s < pacd_pkg::NSplits; s++) begin
         for (int m = 0; m < pacd_pkg::MSub; m++) begin
            stage = s * pacd_pkg::MSub + m;
            idx   = 0;
            for (int b = 0; b < pacd_pkg::NBits; b++) begin
               pos = stage * pacd_pkg::NBits + b;
               if (pos < pacd_pkg::CodeW && code[pos]) idx |= 1 << b;
            end
            rows[m] = stage * pacd_pkg::EntriesPerBook + idx;
         end
         for (int k = 0; k < pacd_pkg::DSub; k++) begin
            acc = 0;
            for (int m = 0; m < pacd_pkg::MSub; m++)
               if (rows[m] * pacd_pkg::DSub + k < pacd_pkg::StoreDepth)
                  acc += book_mirror[rows[m] * pacd_pkg::DSub + k];
            e.out_dim   = pacd_pkg::OutDimW'(s * pacd_pkg::DSub + k);
            e.out_value = acc[pacd_pkg::OutValueW-1:0];
            e.last      = (s == pacd_pkg::NSplits - 1) && (k == pacd_pkg::DSub - 1);
            expected_dims.insert(expected_dims.size(), e);
         end
      end
   endtask

   function automatic void report(input string field, input int want, input int got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_cnt++;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (accepted_cnt != pushed_cnt || expected_dims.size() != 0) @(negedge clock);
   endtask

   // Driver: present the next beat unless holding or idling
   always @(posedge clock) begin
      if (reset) begin
         req.valid         <= 1'b0;
         req.cmd           <= pacd_pkg::CmdWrite;
         req.row_index     <= '0;
         req.dim_index     <= '0;
         req.element_value <= '0;
         req.packed_code   <= '0;
      end else if (!req.valid || req.ready) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req.valid         <= 1'b1;
            req.cmd           <= req_backlog[0].cmd;
            req.row_index     <= req_backlog[0].row_index;
            req.dim_index     <= req_backlog[0].dim_index;
            req.element_value <= req_backlog[0].element_value;
            req.packed_code   <= req_backlog[0].packed_code;
            void'(req_backlog.pop_front());
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor: update the mirror on accepted beats and check results
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset) begin
         if (req.valid && req.ready) begin
            accepted_cnt++;
            if (req.cmd == pacd_pkg::CmdWrite) begin
               if (req.row_index < pacd_pkg::NRows && req.dim_index < pacd_pkg::DSub)
                  book_mirror[req.row_index * pacd_pkg::DSub + req.dim_index] =
                     req.element_value;
            end else begin
               predict_decode(req.packed_code);
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_dims.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual dim %0d value %0d",
                        $time, rsp.out_dim, rsp.out_value);
               mismatch_cnt++;
            end else begin
               want = expected_dims.pop_front();
               if (rsp.out_dim !== want.out_dim) report("out_dim", want.out_dim, rsp.out_dim);
               if (rsp.out_value !== want.out_value)
                  report("out_value", want.out_value, rsp.out_value);
               if (rsp.last !== want.last) report("last", want.last, rsp.last);
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WatchLimit) begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, WatchLimit);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int       seg_items;
      int       roll;
      pace_type seg_pace;
      reset = 1'b1;
      for (int st = 0; st < Stages; st++) full_cnt[st] = 0;
      set_pace(PaceFree);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: entry 0 at the most negative value in split 0, at the max elsewhere
      for (int st = 0; st < Stages; st++) begin
         if (st < pacd_pkg::MSub) begin
            load_row(st, 0, FillMin);
         end else begin
            load_row(st, 0, FillMax);
         end
      end
      push_decode('0);
      push_decode('0);
      wait_drained();

      // Random: row loads, stray writes and decodes over rotating pacing
      for (int seg = 0; seg < Segments; seg++) begin
         case (seg % 4)
            0:       seg_pace = PaceSendIdle;
            1:       seg_pace = PaceRecvStall;
            2:       seg_pace = PaceBoth;
            default: seg_pace = PaceFree;
         endcase
         set_pace(seg_pace);
         seg_items = 0;
         while (seg_items < RandomItems / Segments) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               load_row($urandom_range(0, Stages - 1),
                        $urandom_range(0, pacd_pkg::EntriesPerBook - 1), FillRandom);
               seg_items += pacd_pkg::DSub;
            end else if (roll < 40) begin
               push_write($urandom_range(0, pacd_pkg::NRows - 1),
                          $urandom_range(0, pacd_pkg::DSub - 1), pacd_pkg::ElemW'($urandom));
               seg_items++;
            end else begin
               push_decode(pick_code());
               seg_items++;
            end
         end
         // Hold the sender until every owed element has come back
         wait_drained();
      end

      repeat (TailCycles) @(posedge clock);
      if (mismatch_cnt == 0 && expected_dims.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/pacd_pkg.sv
rtl/pacd_req_if.sv
rtl/pacd_rsp_if.sv
rtl/product_additive_code_decoder_unit.sv
verif/product_additive_code_decoder_unit_test.sv
